// ----- hw/rtl/v3a_pkg.sv -----
// shared constants, codes and pipeline record types for the vector alu
package v3a_pkg;

    // fixed point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int ITERS     = FRAC_BITS + 1;
    localparam int BIT_W     = $clog2(ITERS);
    localparam int SW        = 66;
    localparam int CW        = 2 * FRAC_BITS + 68;

    // operation codes
    localparam logic [2:0] FN_ADD   = 3'd0;
    localparam logic [2:0] FN_SUB   = 3'd1;
    localparam logic [2:0] FN_DOT   = 3'd2;
    localparam logic [2:0] FN_CROSS = 3'd3;
    localparam logic [2:0] FN_NORM  = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // saturation bounds and rounding constant
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);
    localparam logic signed [SW-1:0] HALF    = SW'(1) <<< (FRAC_BITS - 1);

    // after the multiplier stage
    typedef struct packed {
        logic [2:0]        func;
        logic [2:0]        sgn;
        logic [5:0][63:0]  prod;
        logic [2:0][32:0]  lin;
    } t_s1;

    // after the sum and rounding stage
    typedef struct packed {
        logic [2:0]          func;
        logic [2:0]          sgn;
        logic [2:0][SW-1:0]  pre;
        logic [63:0]         s;
        logic [2:0][CW-1:0]  t;
    } t_s2;

    // one root iteration stage
    typedef struct packed {
        logic [2:0]             func;
        logic [2:0]             sgn;
        logic [2:0][31:0]       res;
        logic [1:0]             status;
        logic [63:0]            s;
        logic [2:0][CW-1:0]     t;
        logic [2:0][CW-1:0]     p;
        logic [2:0][CW-1:0]     q;
        logic [2:0][ITERS-1:0]  root;
    } t_it;

endpackage

// ----- hw/rtl/v3a_norm_step.sv -----
// one bit of the normalize quotient: trial square against the scaled target
module v3a_norm_step (
    input  logic [v3a_pkg::BIT_W-1:0] i_bit,
    input  logic [63:0]               i_s,
    input  logic [v3a_pkg::CW-1:0]    i_t,
    input  logic [v3a_pkg::CW-1:0]    i_p,
    input  logic [v3a_pkg::CW-1:0]    i_q,
    input  logic [v3a_pkg::ITERS-1:0] i_root,
    output logic [v3a_pkg::CW-1:0]    o_p,
    output logic [v3a_pkg::CW-1:0]    o_q,
    output logic [v3a_pkg::ITERS-1:0] o_root
);
    import v3a_pkg::*;

    logic [CW-1:0] w_s_ext;
    logic [CW-1:0] w_cand;
    logic          w_take;

    // (q + 2^bit)^2 * s from q^2 * s and q * s
    assign w_s_ext = CW'(i_s);
    assign w_cand  = i_p + ((i_q << i_bit) << 1) + (w_s_ext << {i_bit, 1'b0});
    assign w_take  = (w_cand <= i_t);

    // keep the bit when the trial square does not exceed the target
    always_comb begin
        o_p    = i_p;
        o_q    = i_q;
        o_root = i_root;
        if (w_take) begin
            o_p    = w_cand;
            o_q    = i_q + (w_s_ext << i_bit);
            o_root = i_root | (ITERS'(1) << i_bit);
        end
    end

endmodule

// ----- hw/rtl/vec3_alu.sv -----
// 3-component signed fixed point vector alu, fully pipelined
//
// Input channel: i_valid / o_stall with i_func and vectors a, b. Output
// channel: o_valid / i_stall with o_r_x, o_r_y, o_r_z and o_status. A
// transfer happens on a rising edge with valid high and stall low.
// Operations: add, subtract, dot (result in x, y and z zero), cross and
// normalize of a. Out of range results saturate and report status 1;
// normalize of a zero vector gives zeros and status 2; unused codes give
// zeros and status 0.
// Pipeline for Q16.16: one multiplier stage, one sum and rounding stage,
// FRAC_BITS + 1 stages of the normalize root, one bit per stage, and the
// output register. One item is accepted every cycle while no output item
// is held by i_stall.
// When the output is held by i_stall the whole pipeline freezes and o_stall
// is raised in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the payload registers keep garbage until
// overwritten.
module vec3_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_r_x,
    output logic signed [31:0] o_r_y,
    output logic signed [31:0] o_r_z,
    output logic [1:0]         o_status
);
    import v3a_pkg::*;

    logic              w_adv;
    logic signed [31:0] w_ma [6];
    logic signed [31:0] w_mb [6];
    t_s1               n_s1, r_s1;
    t_s2               n_s2, r_s2;
    t_it               w_head;
    t_it               r_it [ITERS];
    t_it               n_it [ITERS];
    wire t_it          w_src [ITERS];
    wire [2:0][CW-1:0]    w_p_n [ITERS];
    wire [2:0][CW-1:0]    w_q_n [ITERS];
    wire [2:0][ITERS-1:0] w_root_n [ITERS];
    logic              r_v1, r_v2;
    logic [ITERS-1:0]  r_vit;
    logic              r_out_valid;
    logic [31:0]       r_rx, r_ry, r_rz;
    logic [1:0]        r_st;
    logic [31:0]       n_rx, n_ry, n_rz;
    logic [1:0]        n_st;

    // global advance: freeze when the output holds an item that is stalled
    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    // multiplier operand selection
    always_comb begin
        w_ma[0] = i_a_x; w_mb[0] = i_b_x;
        w_ma[1] = i_a_y; w_mb[1] = i_b_y;
        w_ma[2] = i_a_z; w_mb[2] = i_b_z;
        w_ma[3] = i_a_x; w_mb[3] = i_b_z;
        w_ma[4] = i_a_x; w_mb[4] = i_b_y;
        w_ma[5] = i_a_y; w_mb[5] = i_b_x;
        case (i_func)
            FN_CROSS: begin
                w_ma[0] = i_a_y; w_mb[0] = i_b_z;
                w_ma[1] = i_a_z; w_mb[1] = i_b_y;
                w_ma[2] = i_a_z; w_mb[2] = i_b_x;
            end
            FN_NORM: begin
                w_mb[0] = i_a_x;
                w_mb[1] = i_a_y;
                w_mb[2] = i_a_z;
            end
            default: begin
            end
        endcase
    end

    // stage 1: products and linear sums
    always_comb begin
        n_s1.func = i_func;
        n_s1.sgn  = {i_a_z[31], i_a_y[31], i_a_x[31]};
        for (int k = 0; k < 6; k++) begin
            n_s1.prod[k] = 64'(w_ma[k]) * 64'(w_mb[k]);
        end
        if (i_func == FN_SUB) begin
            n_s1.lin[0] = 33'(i_a_x) - 33'(i_b_x);
            n_s1.lin[1] = 33'(i_a_y) - 33'(i_b_y);
            n_s1.lin[2] = 33'(i_a_z) - 33'(i_b_z);
        end else begin
            n_s1.lin[0] = 33'(i_a_x) + 33'(i_b_x);
            n_s1.lin[1] = 33'(i_a_y) + 33'(i_b_y);
            n_s1.lin[2] = 33'(i_a_z) + 33'(i_b_z);
        end
    end

    // stage 2: product sums, rounding, normalize setup
    always_comb begin
        logic signed [SW-1:0] e [6];
        logic signed [SW-1:0] dot, cx, cy, cz;
        for (int k = 0; k < 6; k++) begin
            e[k] = SW'($signed(r_s1.prod[k]));
        end
        dot = e[0] + e[1] + e[2];
        cx  = e[0] - e[1];
        cy  = e[2] - e[3];
        cz  = e[4] - e[5];
        n_s2.func = r_s1.func;
        n_s2.sgn  = r_s1.sgn;
        n_s2.s    = dot[63:0];
        for (int k = 0; k < 3; k++) begin
            n_s2.t[k] = CW'(r_s1.prod[k]) << (2 * FRAC_BITS);
        end
        n_s2.pre = '0;
        case (r_s1.func)
            FN_ADD, FN_SUB: begin
                for (int k = 0; k < 3; k++) begin
                    n_s2.pre[k] = SW'($signed(r_s1.lin[k]));
                end
            end
            FN_DOT: begin
                n_s2.pre[0] = (dot + HALF) >>> FRAC_BITS;
            end
            FN_CROSS: begin
                n_s2.pre[0] = (cx + HALF) >>> FRAC_BITS;
                n_s2.pre[1] = (cy + HALF) >>> FRAC_BITS;
                n_s2.pre[2] = (cz + HALF) >>> FRAC_BITS;
            end
            default: begin
            end
        endcase
    end

    // saturation and root iteration seed
    always_comb begin
        logic any_sat;
        any_sat     = 1'b0;
        w_head.func = r_s2.func;
        w_head.sgn  = r_s2.sgn;
        w_head.s    = r_s2.s;
        w_head.t    = r_s2.t;
        w_head.p    = '0;
        w_head.q    = '0;
        w_head.root = '0;
        for (int k = 0; k < 3; k++) begin
            if ($signed(r_s2.pre[k]) > SAT_MAX) begin
                w_head.res[k] = SAT_MAX[31:0];
                any_sat       = 1'b1;
            end else if ($signed(r_s2.pre[k]) < SAT_MIN) begin
                w_head.res[k] = SAT_MIN[31:0];
                any_sat       = 1'b1;
            end else begin
                w_head.res[k] = r_s2.pre[k][31:0];
            end
        end
        w_head.status = any_sat ? ST_SAT : ST_OK;
    end

    // root iteration stages, most significant quotient bit first
    assign w_src[0] = w_head;
    for (genvar k = 0; k < ITERS; k++) begin : g_it
        if (k > 0) begin : g_link
            assign w_src[k] = r_it[k-1];
        end
        for (genvar j = 0; j < 3; j++) begin : g_comp
            v3a_norm_step u_step (
                .i_bit  (BIT_W'(FRAC_BITS - k)),
                .i_s    (w_src[k].s),
                .i_t    (w_src[k].t[j]),
                .i_p    (w_src[k].p[j]),
                .i_q    (w_src[k].q[j]),
                .i_root (w_src[k].root[j]),
                .o_p    (w_p_n[k][j]),
                .o_q    (w_q_n[k][j]),
                .o_root (w_root_n[k][j])
            );
        end
    end

    // next contents of the root iteration stages
    always_comb begin
        for (int k = 0; k < ITERS; k++) begin
            n_it[k]      = w_src[k];
            n_it[k].p    = w_p_n[k];
            n_it[k].q    = w_q_n[k];
            n_it[k].root = w_root_n[k];
        end
    end

    // final select: normalize result or arithmetic result
    always_comb begin
        logic [2:0][31:0] mag;
        for (int k = 0; k < 3; k++) begin
            mag[k] = 32'(r_it[ITERS-1].root[k]);
        end
        n_rx = r_it[ITERS-1].res[0];
        n_ry = r_it[ITERS-1].res[1];
        n_rz = r_it[ITERS-1].res[2];
        n_st = r_it[ITERS-1].status;
        if (r_it[ITERS-1].func == FN_NORM) begin
            if (r_it[ITERS-1].s == 64'd0) begin
                n_rx = '0;
                n_ry = '0;
                n_rz = '0;
                n_st = ST_ZERO;
            end else begin
                n_rx = r_it[ITERS-1].sgn[0] ? (~mag[0] + 32'd1) : mag[0];
                n_ry = r_it[ITERS-1].sgn[1] ? (~mag[1] + 32'd1) : mag[1];
                n_rz = r_it[ITERS-1].sgn[2] ? (~mag[2] + 32'd1) : mag[2];
                n_st = ST_OK;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_vit       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_vit       <= {r_vit[ITERS-2:0], r_v2};
            r_out_valid <= r_vit[ITERS-1];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            for (int k = 0; k < ITERS; k++) begin
                r_it[k] <= n_it[k];
            end
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_rz <= n_rz;
            r_st <= n_st;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_r_x    = r_rx;
    assign o_r_y    = r_ry;
    assign o_r_z    = r_rz;
    assign o_status = r_st;

    // zero-vector normalize always reports a zero vector
    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_ZERO |-> o_r_x == 0 && o_r_y == 0 && o_r_z == 0)
        else $error("zero status with nonzero result");

    // saturation status implies some component sits at a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_SAT |->
            o_r_x == 32'sh7fffffff || o_r_x == 32'sh80000000 ||
            o_r_y == 32'sh7fffffff || o_r_y == 32'sh80000000 ||
            o_r_z == 32'sh7fffffff || o_r_z == 32'sh80000000)
        else $error("saturation status without clamped component");

    // backpressure only comes from a held output item
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

endmodule

// ----- verif/vec3_alu_test.sv -----
// self-checking testbench for the 3-component fixed point vector alu
module vec3_alu_test;
    import v3a_pkg::*;

    // one operation request and one result record
    typedef struct {
        logic [2:0]         func;
        logic signed [31:0] ax, ay, az, bx, by, bz;
    } vec_op_t;

    typedef struct {
        logic signed [31:0] rx, ry, rz;
        logic [1:0]         status;
    } vec_res_t;

    localparam int LATENCY = FRAC_BITS + 4;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_func = '0;
    logic signed [31:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [31:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_r_x, o_r_y, o_r_z;
    logic [1:0]         o_status;

    vec_op_t  pending_ops[$];
    vec_res_t expected_res[$];
    int       errors = 0;
    int       results_seen = 0;
    int       ops_sent = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;

    vec3_alu dut (.*);

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // saturate a wide value to 32 bits, flagging a clamp
    function automatic logic signed [31:0] clamp32(input logic signed [69:0] v,
                                                   inout logic sat);
        if (v > 70'sd2147483647) begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -70'sd2147483648) begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // exact product sum rescaled with round half up
    function automatic logic signed [69:0] rescale(input logic signed [69:0] v);
        logic signed [69:0] t;
        t = v + (70'sd1 <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    // floor(m * 2^F / sqrt(s)) by bitwise search on squares
    function automatic logic [31:0] unit_comp(input logic [32:0] m, input logic [66:0] s);
        logic [131:0] target;
        logic [131:0] trial;
        logic [31:0]  q;
        logic [31:0]  c;
        target = ({66'd0, m} * {66'd0, m}) << (2 * FRAC_BITS);
        q = 0;
        for (int b = FRAC_BITS; b >= 0; b--) begin
            c = q | (32'd1 << b);
            trial = {100'd0, c} * {100'd0, c} * {65'd0, s};
            if (trial <= target) q = c;
        end
        return q;
    endfunction

    function automatic vec_res_t vec_predict(input vec_op_t op);
        vec_res_t r;
        logic sat;
        logic signed [69:0] ax, ay, az, bx, by, bz;
        logic [32:0] mx, my, mz;
        logic [66:0] s;
        sat = 1'b0;
        r = '{0, 0, 0, ST_OK};
        ax = op.ax; ay = op.ay; az = op.az;
        bx = op.bx; by = op.by; bz = op.bz;
        case (op.func)
            FN_ADD: begin
                r.rx = clamp32(ax + bx, sat);
                r.ry = clamp32(ay + by, sat);
                r.rz = clamp32(az + bz, sat);
            end
            FN_SUB: begin
                r.rx = clamp32(ax - bx, sat);
                r.ry = clamp32(ay - by, sat);
                r.rz = clamp32(az - bz, sat);
            end
            FN_DOT: begin
                r.rx = clamp32(rescale(ax * bx + ay * by + az * bz), sat);
            end
            FN_CROSS: begin
                r.rx = clamp32(rescale(ay * bz - az * by), sat);
                r.ry = clamp32(rescale(az * bx - ax * bz), sat);
                r.rz = clamp32(rescale(ax * by - ay * bx), sat);
            end
            FN_NORM: begin
                mx = ax < 0 ? -ax : ax;
                my = ay < 0 ? -ay : ay;
                mz = az < 0 ? -az : az;
                s = mx * mx + my * my + mz * mz;
                if (s == 0) begin
                    r.status = ST_ZERO;
                end else begin
                    r.rx = unit_comp(mx, s);
                    r.ry = unit_comp(my, s);
                    r.rz = unit_comp(mz, s);
                    if (ax < 0) r.rx = -r.rx;
                    if (ay < 0) r.ry = -r.ry;
                    if (az < 0) r.rz = -r.rz;
                end
            end
            default: ;
        endcase
        if (sat) r.status = ST_SAT;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    // driver: next item goes out once the current one transfers
    always @(posedge i_clk) begin
        if (i_rst_n && (!i_valid || !o_stall)) begin
            if (i_valid) begin
                ops_sent++;
            end
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                vec_op_t op;
                op = pending_ops.pop_front();
                expected_res.push_back(vec_predict(op));
                i_valid <= 1'b1;
                i_func <= op.func;
                i_a_x <= op.ax; i_a_y <= op.ay; i_a_z <= op.az;
                i_b_x <= op.bx; i_b_y <= op.by; i_b_z <= op.bz;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transfer and randomize the stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_res.size() == 0) begin
                    errors++;
                    $display("result transfer with nothing expected");
                end else begin
                    vec_res_t w;
                    w = expected_res.pop_front();
                    if (o_r_x !== w.rx) report_mismatch("r_x", o_r_x, w.rx);
                    if (o_r_y !== w.ry) report_mismatch("r_y", o_r_y, w.ry);
                    if (o_r_z !== w.rz) report_mismatch("r_z", o_r_z, w.rz);
                    if (o_status !== w.status)
                        report_mismatch("status", o_status, w.status);
                end
                results_seen++;
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed($urandom_range(2 * 65536)) - 65536;
            3: return $signed($urandom_range(512)) - 256;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(input logic [2:0] f, input logic signed [31:0] ax, ay, az,
                            bx, by, bz);
        pending_ops.push_back('{f, ax, ay, az, bx, by, bz});
    endtask

    // stimulus in phases with different idle and stall mixes
    initial begin
        localparam logic signed [31:0] PMAX = 32'sh7fffffff;
        localparam logic signed [31:0] PMIN = 32'sh80000000;
        localparam logic signed [31:0] ONE = 32'sh00010000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, every code, zero vector, rounding ties
        queue_op(FN_ADD, PMAX, PMIN, ONE, 1, -1, ONE);
        queue_op(FN_ADD, PMIN, PMAX, 0, -1, 1, 0);
        queue_op(FN_SUB, PMIN, PMAX, ONE, 1, -1, -ONE);
        queue_op(FN_SUB, PMAX, PMIN, 0, PMIN, PMAX, 0);
        queue_op(FN_DOT, ONE, 2 * ONE, 3 * ONE, ONE, ONE, ONE);
        queue_op(FN_DOT, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX);
        queue_op(FN_DOT, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
        queue_op(FN_DOT, 32'sh8000, 1, 0, 1, 0, 0);
        queue_op(FN_DOT, -32'sh8000, 1, 0, 1, 0, 0);
        queue_op(FN_CROSS, ONE, 0, 0, 0, ONE, 0);
        queue_op(FN_CROSS, 0, 0, ONE, ONE, 0, 0);
        queue_op(FN_CROSS, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX);
        queue_op(FN_NORM, 0, 0, 0, 5, 5, 5);
        queue_op(FN_NORM, PMIN, PMIN, PMIN, 0, 0, 0);
        queue_op(FN_NORM, PMAX, 0, 0, 0, 0, 0);
        queue_op(FN_NORM, 1, -1, 1, 0, 0, 0);
        queue_op(FN_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0);
        queue_op(3'd5, 1, 2, 3, 4, 5, 6);
        queue_op(3'd6, PMAX, 0, 0, 0, 0, 0);
        queue_op(3'd7, -1, -1, -1, -1, -1, -1);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 87; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            for (int n = 0; n < 150; n++) begin
                logic [2:0] f;
                f = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                              : 3'($urandom_range(4));
                queue_op(f, rand_comp(), rand_comp(), rand_comp(),
                         rand_comp(), rand_comp(), rand_comp());
            end
            while (pending_ops.size() > 0) @(posedge i_clk);
            // after the last phase, clear the idle and stall rates
            if (ph == 3) begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
        end
        while (pending_ops.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_res.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        $display("ran %0d operations through add, sub, dot, cross, normalize, spare codes",
                 ops_sent);
        $display("checked %0d results under four idle and stall mixes", results_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/v3a_pkg.sv
hw/rtl/v3a_norm_step.sv
hw/rtl/vec3_alu.sv
verif/vec3_alu_test.sv
